// File: hdl/tdcc_pkg.sv
package tdcc_pkg;

  localparam logic [7:0] STX_BYTE = 8'h02;

  localparam logic [15:0] CRC_POLY_RST = 16'h8005;
  localparam logic [7:0]  ADDR_BYTE_RST = 8'h80;
  localparam logic [15:0] MAX_LEN_RST = 16'd1024;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_BYTE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 8'd2;

  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_TOO_LONG = 2'd2
  } frame_status_t;

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_ADDR   = 7'b0000010,
    PH_LEN_LO = 7'b0000100,
    PH_LEN_HI = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CKS_LO = 7'b0100000,
    PH_CKS_HI = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [15:0] crc_poly;
    logic [7:0]  address_byte;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]    data_byte;
    logic          payload_valid;
    logic          first_of_payload;
    logic          frame_end;
    frame_status_t frame_status;
    logic [15:0]   frame_length;
  } result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] prev,
                                           input logic [7:0] b, input logic [15:0] poly);
    logic [15:0] c;
    c = {crc[14:0], 1'b0};
    if (crc[15]) begin
      c = c ^ poly;
    end
    return c ^ {prev, b};
  endfunction

endpackage

// File: hdl/tdcc_cfg_regs.sv
module tdcc_cfg_regs
  import tdcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_poly <= CRC_POLY_RST;
      cfg_r.address_byte <= ADDR_BYTE_RST;
      cfg_r.max_length <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CRC_POLY) begin
        cfg_r.crc_poly <= cfg_data;
      end
      if (cfg_index == REG_ADDR_BYTE) begin
        cfg_r.address_byte <= cfg_data[7:0];
      end
      if (cfg_index == REG_MAX_LEN) begin
        cfg_r.max_length <= cfg_data;
      end
    end
  end

endmodule

// File: hdl/tdcc_frame_fsm.sv
module tdcc_frame_fsm
  import tdcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  cks_lo_r, cks_lo_nxt;
  logic [15:0] len_full;
  logic [15:0] crc_fed;

  assign len_full = {rx_byte, len_r[7:0]};
  assign crc_fed = crc_step(crc_r, prev_r, rx_byte, cfg.crc_poly);

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt = crc_r;
    prev_nxt = prev_r;
    len_nxt = len_r;
    left_nxt = left_r;
    cks_lo_nxt = cks_lo_r;
    res.data_byte = rx_byte;
    res.payload_valid = 1'b0;
    res.first_of_payload = 1'b0;
    res.frame_end = 1'b0;
    res.frame_status = ST_GOOD;
    res.frame_length = 16'd0;
    unique case (phase_r)
      PH_ADDR: begin
        if (rx_byte == cfg.address_byte) begin
          crc_nxt = crc_fed;
          prev_nxt = rx_byte;
          phase_nxt = PH_LEN_LO;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        crc_nxt = crc_fed;
        prev_nxt = rx_byte;
        len_nxt = {8'h00, rx_byte};
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        crc_nxt = crc_fed;
        prev_nxt = rx_byte;
        len_nxt = len_full;
        if (len_full > cfg.max_length) begin
          res.frame_end = 1'b1;
          res.frame_status = ST_TOO_LONG;
          res.frame_length = len_full;
          phase_nxt = PH_HUNT;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_CKS_LO;
        end else begin
          left_nxt = len_full;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        crc_nxt = crc_fed;
        prev_nxt = rx_byte;
        res.payload_valid = 1'b1;
        res.first_of_payload = (left_r == len_r);
        left_nxt = left_r - 16'd1;
        if (left_r == 16'd1) begin
          phase_nxt = PH_CKS_LO;
        end
      end
      PH_CKS_LO: begin
        cks_lo_nxt = rx_byte;
        phase_nxt = PH_CKS_HI;
      end
      PH_CKS_HI: begin
        res.frame_end = 1'b1;
        res.frame_status = ({rx_byte, cks_lo_r} == crc_r) ? ST_GOOD : ST_CRC_ERR;
        res.frame_length = len_r;
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == STX_BYTE) begin
          crc_nxt = crc_step(16'd0, 8'd0, rx_byte, cfg.crc_poly);
          prev_nxt = rx_byte;
          phase_nxt = PH_ADDR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      crc_r <= 16'd0;
      prev_r <= 8'd0;
      len_r <= 16'd0;
      left_r <= 16'd0;
      cks_lo_r <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      crc_r <= crc_nxt;
      prev_r <= prev_nxt;
      len_r <= len_nxt;
      left_r <= left_nxt;
      cks_lo_r <= cks_lo_nxt;
    end
  end

endmodule

// File: hdl/telegram_deframer_crc_check.sv
// Serial telegram deframer: every received byte comes out again, one output beat per input
// beat, marked as payload when it lies in a frame's data section, with tlast and a status on
// the last checksum byte of a frame or on a rejected length. The block takes one byte per
// clock cycle while the output is not stalled, and a beat leaves through an input register
// and then a result register, with the checksum and state update done between them.
// Configuration writes are accepted in any cycle and are meant to be done while no
// byte is in flight.
module telegram_deframer_crc_check
  import tdcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [9:8] frame_status,
                                             // [25:10] frame_length, [31:26] zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] payload_valid, [1] first_of_payload
  output logic                   out_tlast,  // frame_end
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    res;
  logic       advance;
  logic       step;

  assign advance = !out_valid_r || out_tready;
  assign step = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  tdcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tdcc_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, out_res_r.frame_length, out_res_r.frame_status,
                      out_res_r.data_byte};
  assign out_tuser = {out_res_r.first_of_payload, out_res_r.payload_valid};
  assign out_tlast = out_res_r.frame_end;

`ifndef SYNTHESIS
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[25:8] == 18'd0)
    else $error("frame status or length set on a beat that does not end a frame");

  a_first_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && !out_tlast)
    else $error("first payload beat not marked as payload");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:8] != 2'd3)
    else $error("undefined frame status code");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("processed byte did not reach the result register");
`endif

endmodule
